/* hdl/erm_pkg.sv */
package erm_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int OUT_FRAC_BITS = 14;
   localparam int WORK_FRAC     = 30;
   localparam int ATAN_ENTRIES  = 24;
   localparam int ROUND_SHIFT   = WORK_FRAC - OUT_FRAC_BITS;
   localparam int LANE_STAGES   = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

   localparam logic signed [15:0] ANGLE_LIMIT  = 16'sd23040;
   localparam logic signed [25:0] QUARTER_TURN = 26'sd5898240;
   localparam logic signed [25:0] HALF_TURN    = 26'sd11796480;
   localparam logic signed [31:0] GAIN_START   = 32'sd652032874;

   typedef struct packed {
      logic signed [15:0] yaw_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] roll_angle;
   } req_type;

   typedef struct packed {
      logic signed [15:0] r00;
      logic signed [15:0] r01;
      logic signed [15:0] r02;
      logic signed [15:0] r10;
      logic signed [15:0] r11;
      logic signed [15:0] r12;
      logic signed [15:0] r20;
      logic signed [15:0] r21;
      logic signed [15:0] r22;
   } rsp_type;

   // atan(2^-i) in degrees times 2^16
   function automatic logic signed [25:0] atan_deg(input logic [4:0] idx);
      logic signed [25:0] v;
      case (idx)
         5'd0:    v = 26'sd2949120;
         5'd1:    v = 26'sd1740967;
         5'd2:    v = 26'sd919879;
         5'd3:    v = 26'sd466945;
         5'd4:    v = 26'sd234379;
         5'd5:    v = 26'sd117304;
         5'd6:    v = 26'sd58666;
         5'd7:    v = 26'sd29335;
         5'd8:    v = 26'sd14668;
         5'd9:    v = 26'sd7334;
         5'd10:   v = 26'sd3667;
         5'd11:   v = 26'sd1833;
         5'd12:   v = 26'sd917;
         5'd13:   v = 26'sd458;
         5'd14:   v = 26'sd229;
         5'd15:   v = 26'sd115;
         5'd16:   v = 26'sd57;
         5'd17:   v = 26'sd29;
         5'd18:   v = 26'sd14;
         5'd19:   v = 26'sd7;
         5'd20:   v = 26'sd4;
         5'd21:   v = 26'sd2;
         5'd22:   v = 26'sd1;
         default: v = 26'sd0;
      endcase
      return v;
   endfunction

   // product of two working values, rounded back to WORK_FRAC fraction bits
   function automatic logic signed [31:0] mul_w(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      logic signed [63:0] p;
      logic signed [63:0] r;
      p = 64'(a) * 64'(b);
      r = (p + (64'sd1 <<< (WORK_FRAC - 1))) >>> WORK_FRAC;
      return r[31:0];
   endfunction

   // round to output precision, clamp to +-1.0 and to 16 bits
   function automatic logic signed [15:0] to_out(input logic signed [32:0] v);
      logic signed [63:0] r;
      logic signed [63:0] lim;
      r = 64'(v);
      if (ROUND_SHIFT > 0) begin
         r = (r + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      end
      lim = 64'sd1 <<< OUT_FRAC_BITS;
      if (r > lim) begin
         r = lim;
      end
      if (r < -lim) begin
         r = -lim;
      end
      if (r > 64'sd32767) begin
         r = 64'sd32767;
      end
      if (r < -64'sd32768) begin
         r = -64'sd32768;
      end
      return r[15:0];
   endfunction

endpackage

/* hdl/erm_cordic.sv */
module erm_cordic (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic signed [15:0] angle,
   output logic               out_valid,
   output logic signed [31:0] sin_out,
   output logic signed [31:0] cos_out
);

   localparam int N = erm_pkg::LANE_STAGES;

   logic               valid_ff [0:N];
   logic               flip_ff  [0:N];
   logic signed [31:0] x_ff     [0:N];
   logic signed [31:0] y_ff     [0:N];
   logic signed [25:0] z_ff     [0:N];

   logic signed [15:0] sat_in;
   logic signed [25:0] z_in;
   logic               flip_in;

   // saturate, scale to degrees times 2^16, fold into +-90 degrees
   always_comb begin
      sat_in = angle;
      if (angle > erm_pkg::ANGLE_LIMIT) begin
         sat_in = erm_pkg::ANGLE_LIMIT;
      end
      if (angle < -erm_pkg::ANGLE_LIMIT) begin
         sat_in = -erm_pkg::ANGLE_LIMIT;
      end
      z_in    = 26'(sat_in) <<< 9;
      flip_in = 1'b0;
      if (z_in > erm_pkg::QUARTER_TURN) begin
         z_in    = z_in - erm_pkg::HALF_TURN;
         flip_in = 1'b1;
      end else if (z_in < -erm_pkg::QUARTER_TURN) begin
         z_in    = z_in + erm_pkg::HALF_TURN;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      flip_ff[0] <= flip_in;
      x_ff[0]    <= erm_pkg::GAIN_START;
      y_ff[0]    <= 32'sd0;
      z_ff[0]    <= z_in;
   end

   for (genvar g = 0; g < N; g++) begin : g_stage
      logic signed [31:0] x_in;
      logic signed [31:0] y_in;
      logic signed [25:0] zn_in;

      always_comb begin
         if (z_ff[g] >= 26'sd0) begin
            x_in  = x_ff[g] - (y_ff[g] >>> g);
            y_in  = y_ff[g] + (x_ff[g] >>> g);
            zn_in = z_ff[g] - erm_pkg::atan_deg(5'(g));
         end else begin
            x_in  = x_ff[g] + (y_ff[g] >>> g);
            y_in  = y_ff[g] - (x_ff[g] >>> g);
            zn_in = z_ff[g] + erm_pkg::atan_deg(5'(g));
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g+1] <= 1'b0;
         end else begin
            valid_ff[g+1] <= valid_ff[g];
         end
         flip_ff[g+1] <= flip_ff[g];
         x_ff[g+1]    <= x_in;
         y_ff[g+1]    <= y_in;
         z_ff[g+1]    <= zn_in;
      end
   end

   logic               out_valid_ff;
   logic signed [31:0] sin_ff;
   logic signed [31:0] cos_ff;

   // undo the half-turn fold
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid_ff[N];
      end
      sin_ff <= flip_ff[N] ? -y_ff[N] : y_ff[N];
      cos_ff <= flip_ff[N] ? -x_ff[N] : x_ff[N];
   end

   assign out_valid = out_valid_ff;
   assign sin_out   = sin_ff;
   assign cos_out   = cos_ff;

endmodule

/* hdl/erm_merge.sv */
module erm_merge (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic signed [31:0]  sy,
   input  logic signed [31:0]  cy,
   input  logic signed [31:0]  sp,
   input  logic signed [31:0]  cp,
   input  logic signed [31:0]  sr,
   input  logic signed [31:0]  cr,
   output logic                out_valid,
   output erm_pkg::rsp_type    out_data
);

   // first products
   logic               v1_ff;
   logic signed [31:0] sysp_ff, cysp_ff, cycr_ff, cysr_ff, sycr_ff, sysr_ff;
   logic signed [31:0] sycp_ff, cycp_ff, cpsr_ff, cpcr_ff, sp1_ff, sr1_ff, cr1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      sysp_ff <= erm_pkg::mul_w(sy, sp);
      cysp_ff <= erm_pkg::mul_w(cy, sp);
      cycr_ff <= erm_pkg::mul_w(cy, cr);
      cysr_ff <= erm_pkg::mul_w(cy, sr);
      sycr_ff <= erm_pkg::mul_w(sy, cr);
      sysr_ff <= erm_pkg::mul_w(sy, sr);
      sycp_ff <= erm_pkg::mul_w(sy, cp);
      cycp_ff <= erm_pkg::mul_w(cy, cp);
      cpsr_ff <= erm_pkg::mul_w(cp, sr);
      cpcr_ff <= erm_pkg::mul_w(cp, cr);
      sp1_ff  <= sp;
      sr1_ff  <= sr;
      cr1_ff  <= cr;
   end

   // triple products through the pitch term
   logic               v2_ff;
   logic signed [31:0] t_sysr_ff, t_syscr_ff, t_cysr_ff, t_cycr_ff;
   logic signed [31:0] cycr2_ff, cysr2_ff, sycr2_ff, sysr2_ff;
   logic signed [31:0] sycp2_ff, cycp2_ff, cpsr2_ff, cpcr2_ff, sp2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      t_sysr_ff  <= erm_pkg::mul_w(sysp_ff, sr1_ff);
      t_syscr_ff <= erm_pkg::mul_w(sysp_ff, cr1_ff);
      t_cysr_ff  <= erm_pkg::mul_w(cysp_ff, sr1_ff);
      t_cycr_ff  <= erm_pkg::mul_w(cysp_ff, cr1_ff);
      cycr2_ff   <= cycr_ff;
      cysr2_ff   <= cysr_ff;
      sycr2_ff   <= sycr_ff;
      sysr2_ff   <= sysr_ff;
      sycp2_ff   <= sycp_ff;
      cycp2_ff   <= cycp_ff;
      cpsr2_ff   <= cpsr_ff;
      cpcr2_ff   <= cpcr_ff;
      sp2_ff     <= sp1_ff;
   end

   erm_pkg::rsp_type   res_in;
   erm_pkg::rsp_type   res_ff;
   logic               v3_ff;

   always_comb begin
      res_in.r00 = erm_pkg::to_out(33'(cycr2_ff) - 33'(t_sysr_ff));
      res_in.r01 = erm_pkg::to_out(-33'(sycp2_ff));
      res_in.r02 = erm_pkg::to_out(33'(cysr2_ff) + 33'(t_syscr_ff));
      res_in.r10 = erm_pkg::to_out(33'(sycr2_ff) + 33'(t_cysr_ff));
      res_in.r11 = erm_pkg::to_out(33'(cycp2_ff));
      res_in.r12 = erm_pkg::to_out(33'(sysr2_ff) - 33'(t_cycr_ff));
      res_in.r20 = erm_pkg::to_out(-33'(cpsr2_ff));
      res_in.r21 = erm_pkg::to_out(33'(sp2_ff));
      res_in.r22 = erm_pkg::to_out(33'(cpcr2_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      res_ff <= res_in;
   end

   assign out_valid = v3_ff;
   assign out_data  = res_ff;

endmodule

/* hdl/euler_to_rotation_matrix.sv */
// Euler angles (yaw, pitch, roll) to rotation matrix Rz(yaw)*Rx(pitch)*Ry(roll).
// Request channel: req_data carries the three angles in 1/128 degree units; a
// transfer happens at a rising edge with start high and busy low. busy is
// always low, so a new item may be started in every cycle.
// Response channel: rsp_data carries the nine Q1.14 matrix entries and is
// valid for exactly one cycle while rsp_strobe is high. The receiver cannot
// hold results off and must take each one in the cycle it is shown.
// Path from the start transfer to the strobe: an angle-folding register,
// one register per CORDIC stage (16 CORDIC stages), a sign-fix register,
// then two multiply stages and one rounding stage.
// Throughput is one item per cycle.
// Three CORDIC lanes, one per angle, run side by side; the combining stage
// forms the nine entries from their sines and cosines.
// Reset (synchronous, active high) clears the valid pipeline so that no
// strobe appears for items in flight; data registers are not cleared.
module euler_to_rotation_matrix (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  erm_pkg::req_type req_data,
   output logic             rsp_strobe,
   output erm_pkg::rsp_type rsp_data
);

   logic               accept;
   logic               yaw_valid, pitch_valid, roll_valid;
   logic signed [31:0] sy, cy, sp, cp, sr, cr;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   erm_cordic u_yaw (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .angle     (req_data.yaw_angle),
      .out_valid (yaw_valid),
      .sin_out   (sy),
      .cos_out   (cy)
   );

   erm_cordic u_pitch (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .angle     (req_data.pitch_angle),
      .out_valid (pitch_valid),
      .sin_out   (sp),
      .cos_out   (cp)
   );

   erm_cordic u_roll (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .angle     (req_data.roll_angle),
      .out_valid (roll_valid),
      .sin_out   (sr),
      .cos_out   (cr)
   );

   erm_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (yaw_valid & pitch_valid & roll_valid),
      .sy        (sy),
      .cy        (cy),
      .sp        (sp),
      .cp        (cp),
      .sr        (sr),
      .cr        (cr),
      .out_valid (rsp_strobe),
      .out_data  (rsp_data)
   );

endmodule
